// ----- src/chte_pkg.sv -----
// Shared types and constants of the chained hash table engine.
package chte_pkg;

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int BC_W     = 7;

    // Largest and reset value of the bucket count register.
    localparam int BC_MAX   = 2 ** BC_W - 1;
    localparam int BC_RESET = 64;

    // Hash multiplier; the product wraps at the key width.
    localparam logic [KEY_W-1:0] HASH_MULT = 32'd4099;

    // Dividend bits retired by the modulo unit in each cycle.
    localparam int MOD_STEPS  = 4;
    localparam int MOD_CYCLES = KEY_W / MOD_STEPS;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_MISS = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_LOOKUP = 1'b1
    } func_t;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [BC_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic            done;
        logic [BC_W-1:0] rem;
    } mod_rsp_t;

endpackage

// ----- src/chte_mod_unit.sv -----
// Iterative modulo unit: restoring remainder, several dividend bits per cycle.
module chte_mod_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  chte_pkg::mod_req_t req,
    output chte_pkg::mod_rsp_t rsp
);
    import chte_pkg::*;

    localparam int CYC_W = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CYC_W-1:0] cnt_reg;
    logic [KEY_W-1:0] quo_reg;
    logic [BC_W-1:0]  rem_reg;
    logic [BC_W-1:0]  div_reg;

    logic [KEY_W-1:0] quo_next;
    logic [BC_W-1:0]  rem_next;

    // Shift in one dividend bit per step, subtract the divisor when it fits.
    always_comb
    begin
        logic [BC_W:0]    t;
        logic [BC_W-1:0]  r;
        logic [KEY_W-1:0] d;
        r = rem_reg;
        d = quo_reg;
        t = '0;
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            t = {r, d[KEY_W-1]};
            d = {d[KEY_W-2:0], 1'b0};
            if (t >= {1'b0, div_reg})
            begin
                t = t - {1'b0, div_reg};
            end
            r = t[BC_W-1:0];
        end
        rem_next = r;
        quo_next = d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CYC_W'(MOD_CYCLES - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- src/chte_node_mem.sv -----
// Node pool memories: key, value and chain link, one write and one read port.
module chte_node_mem #(
    parameter int NUM_NODES = 256
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(NUM_NODES)-1:0] wr_addr,
    input  logic [chte_pkg::KEY_W-1:0]   wr_key,
    input  logic [chte_pkg::VALUE_W-1:0] wr_value,
    input  logic                         wr_next_valid,
    input  logic [$clog2(NUM_NODES)-1:0] wr_next_idx,
    input  logic [$clog2(NUM_NODES)-1:0] rd_addr,
    output logic [chte_pkg::KEY_W-1:0]   rd_key,
    output logic [chte_pkg::VALUE_W-1:0] rd_value,
    output logic                         rd_next_valid,
    output logic [$clog2(NUM_NODES)-1:0] rd_next_idx
);
    import chte_pkg::*;

    localparam int NODE_W = $clog2(NUM_NODES);

    logic [KEY_W-1:0]   key_mem   [NUM_NODES];
    logic [VALUE_W-1:0] value_mem [NUM_NODES];
    logic [NODE_W:0]    link_mem  [NUM_NODES];

    logic [KEY_W-1:0]   key_rd_reg;
    logic [VALUE_W-1:0] value_rd_reg;
    logic [NODE_W:0]    link_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
            link_mem[wr_addr]  <= {wr_next_valid, wr_next_idx};
        end
        key_rd_reg   <= key_mem[rd_addr];
        value_rd_reg <= value_mem[rd_addr];
        link_rd_reg  <= link_mem[rd_addr];
    end

    assign rd_key        = key_rd_reg;
    assign rd_value      = value_rd_reg;
    assign rd_next_valid = link_rd_reg[NODE_W];
    assign rd_next_idx   = link_rd_reg[NODE_W-1:0];

endmodule

// ----- src/chained_hash_table_engine_top.sv -----
// Top level of the chained hash table engine: sequencer, bucket heads, config, output word.
//
// Key to value hash table with separate chaining. Each input word is an insert
// (func 0: key and value) or a lookup (func 1: key); each gives exactly one
// output word with status (0 ok or found, 1 duplicate key, 2 not found, 3 node
// pool full) and found_value (stored value on a hit lookup, else zero). The
// bucket is (key * 4099 mod 2^32) mod bucket_count, taken by an iterative
// modulo unit that retires four dividend bits per cycle. After that the head
// entry is read in states S_HEAD and S_HDAT, and the chain is walked at one
// node per cycle from the node memory's single read port. One item is in
// flight at a time; in_stall is low only when the sequencer is idle, and a
// finished output word waits in its own register so the next item may be
// accepted meanwhile. After reset the engine sweeps the whole bucket head
// memory, one entry per cycle, before it takes the first item; configuration
// writes are taken during that sweep. bucket_count must be written through
// cfg_wr_en and cfg_wr_data only while the engine is idle; the block itself
// does not enforce this. Zero is taken as one and values above NUM_BUCKETS
// are clamped to NUM_BUCKETS. Changing it while entries are stored leaves
// old chains in place, so older keys may no longer be found. Nodes are never
// freed: after NUM_NODES successful inserts every new key reports pool full.
module chained_hash_table_engine_top #(
    parameter int NUM_BUCKETS = 64,
    parameter int NUM_NODES   = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [chte_pkg::BC_W-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [chte_pkg::KEY_W-1:0]    key,
    input  logic [chte_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [chte_pkg::STATUS_W-1:0] status,
    output logic [chte_pkg::VALUE_W-1:0]  found_value
);
    import chte_pkg::*;

    localparam int BKT_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int NODE_W   = $clog2(NUM_NODES);
    localparam int CNT_W    = $clog2(NUM_NODES + 1);
    localparam int BC_LIMIT = (NUM_BUCKETS < BC_MAX) ? NUM_BUCKETS : BC_MAX;
    localparam int BC_INIT  = (BC_RESET < BC_LIMIT) ? BC_RESET : BC_LIMIT;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HASH  = 8'b0000_0100,
        S_HEAD  = 8'b0000_1000,
        S_HDAT  = 8'b0001_0000,
        S_NODE  = 8'b0010_0000,
        S_INS   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Control registers.
    logic [BC_W-1:0]  nb_reg, nb_next;
    logic [BKT_W-1:0] clr_cnt_reg;
    logic [CNT_W-1:0] nodes_used_reg;
    logic             out_valid_reg, out_valid_next;

    // Payload registers of the item in flight and of the output word.
    logic               func_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [BKT_W-1:0]   bucket_reg;
    status_t            res_status_reg, res_status_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    status_t            status_reg;
    logic [VALUE_W-1:0] found_value_reg;

    // Bucket head memory: {valid, head node index} per bucket.
    logic [NODE_W:0]  head_mem [NUM_BUCKETS];
    logic [NODE_W:0]  head_rd_reg;
    logic             head_we;
    logic [BKT_W-1:0] head_waddr;
    logic [NODE_W:0]  head_wdata;

    // Node memory and modulo unit hookup.
    logic               node_we;
    logic [NODE_W-1:0]  node_raddr;
    logic [KEY_W-1:0]   nd_key;
    logic [VALUE_W-1:0] nd_value;
    logic               nd_next_valid;
    logic [NODE_W-1:0]  nd_next_idx;
    mod_req_t           mod_req;
    mod_rsp_t           mod_rsp;

    logic                  in_accept;
    logic                  out_free;
    logic                  is_lookup;
    logic                  pool_full;
    logic [BKT_W+BC_W-1:0] rem_wide;

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_lookup = (func_reg == FN_LOOKUP);
    assign pool_full = (nodes_used_reg == CNT_W'(NUM_NODES));
    assign rem_wide  = {{BKT_W{1'b0}}, mod_rsp.rem};

    // Clamp the bucket count on the way in: zero means one bucket.
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            nb_next = BC_W'(1);
        end
        else if (cfg_wr_data > BC_W'(BC_LIMIT))
        begin
            nb_next = BC_W'(BC_LIMIT);
        end
        else
        begin
            nb_next = cfg_wr_data;
        end
    end

    // Hash at acceptance; the product wraps to the key width.
    assign mod_req.start    = in_accept;
    assign mod_req.dividend = KEY_W'(key * HASH_MULT);
    assign mod_req.divisor  = nb_reg;

    chte_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // Read the head entry of the first node, then follow each node's link.
    assign node_raddr = (state_reg == S_HDAT) ? head_rd_reg[NODE_W-1:0] : nd_next_idx;
    assign node_we    = (state_reg == S_INS);

    chte_node_mem #(
        .NUM_NODES (NUM_NODES)
    ) u_node_mem (
        .clk           (clk),
        .wr_en         (node_we),
        .wr_addr       (nodes_used_reg[NODE_W-1:0]),
        .wr_key        (key_reg),
        .wr_value      (value_reg),
        .wr_next_valid (head_rd_reg[NODE_W]),
        .wr_next_idx   (head_rd_reg[NODE_W-1:0]),
        .rd_addr       (node_raddr),
        .rd_key        (nd_key),
        .rd_value      (nd_value),
        .rd_next_valid (nd_next_valid),
        .rd_next_idx   (nd_next_idx)
    );

    // Sweep zeros into the heads after reset; link a new node at the head on insert.
    assign head_we    = (state_reg == S_CLEAR) || (state_reg == S_INS);
    assign head_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : bucket_reg;
    assign head_wdata = (state_reg == S_CLEAR) ? '0 : {1'b1, nodes_used_reg[NODE_W-1:0]};

    // The read address is always bucket_reg and no head write lands between
    // S_HEAD and S_INS, so head_rd_reg still holds the old head at insert time.
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_rd_reg <= head_mem[bucket_reg];
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && out_stall;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == BKT_W'(NUM_BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (mod_rsp.done)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_HDAT;
            end
            S_HDAT, S_NODE:
            begin
                if ((state_reg == S_NODE) && (nd_key == key_reg))
                begin
                    // Key present: a lookup hits, an insert is a duplicate.
                    state_next      = S_DONE;
                    res_status_next = is_lookup ? ST_OK : ST_DUP;
                    res_value_next  = is_lookup ? nd_value : '0;
                end
                else if ((state_reg == S_HDAT) ? head_rd_reg[NODE_W] : nd_next_valid)
                begin
                    state_next = S_NODE;
                end
                else if (is_lookup)
                begin
                    state_next      = S_DONE;
                    res_status_next = ST_MISS;
                    res_value_next  = '0;
                end
                else if (pool_full)
                begin
                    state_next      = S_DONE;
                    res_status_next = ST_FULL;
                    res_value_next  = '0;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                state_next      = S_DONE;
                res_status_next = ST_OK;
                res_value_next  = '0;
            end
            S_DONE:
            begin
                // Hold the result until the output register frees up.
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            nb_reg         <= BC_W'(BC_INIT);
            clr_cnt_reg    <= '0;
            nodes_used_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                nb_reg <= nb_next;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == S_INS)
            begin
                nodes_used_reg <= nodes_used_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg  <= func;
            key_reg   <= key;
            value_reg <= value;
        end
        if ((state_reg == S_HASH) && mod_rsp.done)
        begin
            bucket_reg <= rem_wide[BKT_W-1:0];
        end
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if ((state_reg == S_DONE) && out_free)
        begin
            status_reg      <= res_status_reg;
            found_value_reg <= res_value_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_value_reg;

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nodes_used_reg <= CNT_W'(NUM_NODES))
        else $error("node pool count beyond pool size");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |=> (nodes_used_reg == CNT_W'($past(nodes_used_reg) + 1'b1)))
        else $error("insert did not advance the pool count");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_free) |=>
            (state_reg == S_DONE && $stable(res_status_reg) && $stable(res_value_reg)))
        else $error("result lost while output word stalled");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == ST_OK || found_value_reg == '0))
        else $error("nonzero found_value on a failed operation");

    a_hash_before_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HASH && mod_rsp.done) |=> (state_reg == S_HEAD))
        else $error("bucket not taken when modulo finished");

endmodule

// ----- tb/hash_table_checker.sv -----
// Checker for the chained hash table engine: predicts every reply word and compares it.
module hash_table_checker #(
    parameter int NUM_BUCKETS = 64,
    parameter int NUM_NODES   = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [chte_pkg::BC_W-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          func,
    input  logic [chte_pkg::KEY_W-1:0]    key,
    input  logic [chte_pkg::VALUE_W-1:0]  value,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [chte_pkg::STATUS_W-1:0] status,
    input  logic [chte_pkg::VALUE_W-1:0]  found_value,
    output int                            replies_owed,
    output int                            mismatches
);
    import chte_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [VALUE_W-1:0]  value;
    } reply_t;

    reply_t expected_replies[$];
    reply_t want;

    // Shadow copy of the table.
    logic [BC_W-1:0]    buckets_cfg;
    int                 head_node [NUM_BUCKETS];
    logic               head_live [NUM_BUCKETS];
    logic [KEY_W-1:0]   node_key  [NUM_NODES];
    logic [VALUE_W-1:0] node_value[NUM_NODES];
    int                 node_link [NUM_NODES];
    logic               link_live [NUM_NODES];
    int                 nodes_taken;

    initial
    begin
        replies_owed = 0;
        mismatches   = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_word);
        $display("%0t hash table reply %s: got %h, want %h", $time, what, got, exp_word);
        mismatches++;
    endtask

    // Apply one insert or lookup to the shadow table and return its reply.
    function automatic reply_t table_access(input func_t op, input logic [KEY_W-1:0] k,
                                            input logic [VALUE_W-1:0] v);
        logic [KEY_W-1:0] scrambled;
        logic [31:0]      nb;
        int               b;
        int               n;
        int               where;
        int               steps;
        logic             live;
        logic             hit;
        reply_t           r;

        nb = 32'(buckets_cfg);
        if (nb == 0)
            nb = 1;
        if (nb > NUM_BUCKETS)
            nb = NUM_BUCKETS;
        scrambled = k * HASH_MULT;
        b = int'(scrambled % nb);

        hit   = 1'b0;
        where = 0;
        live  = head_live[b];
        n     = head_node[b];
        steps = 0;
        while (live && !hit && steps < NUM_NODES)
        begin
            if (node_key[n] == k)
            begin
                hit   = 1'b1;
                where = n;
            end
            else
            begin
                live = link_live[n];
                n    = node_link[n];
                steps++;
            end
        end

        r.value = '0;
        if (op == FN_LOOKUP)
        begin
            if (hit)
            begin
                r.status = ST_OK;
                r.value  = node_value[where];
            end
            else
                r.status = ST_MISS;
        end
        else if (hit)
            r.status = ST_DUP;
        else if (nodes_taken >= NUM_NODES)
            r.status = ST_FULL;
        else
        begin
            node_key[nodes_taken]   = k;
            node_value[nodes_taken] = v;
            node_link[nodes_taken]  = head_node[b];
            link_live[nodes_taken]  = head_live[b];
            head_node[b]            = nodes_taken;
            head_live[b]            = 1'b1;
            nodes_taken++;
            r.status = ST_OK;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buckets_cfg = BC_W'(BC_RESET);
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                head_node[i] = 0;
                head_live[i] = 1'b0;
            end
            nodes_taken = 0;
            expected_replies.delete();
            replies_owed = 0;
        end
        else
        begin
            if (cfg_wr_en)
                buckets_cfg = cfg_wr_data;
            // Compare the outgoing word before predicting a new one: an item
            // accepted on this edge cannot have its reply on the same edge.
            if (out_valid && !out_stall)
            begin
                if (expected_replies.size() == 0)
                    report_mismatch("unexpected word, status", 32'(status), '0);
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (found_value !== want.value)
                        report_mismatch("found_value", found_value, want.value);
                end
            end
            if (in_valid && !in_stall)
                expected_replies.push_back(table_access(func_t'(func), key, value));
            replies_owed = expected_replies.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the chained hash table engine: stimulus, stalls and verdict.
module tb;
    import chte_pkg::*;

    localparam int NUM_BUCKETS  = 64;
    localparam int NUM_NODES    = 256;
    // The worst case per word is a walk of a full single chain, plus the
    // longest gaps on both sides; the limit is several times that over the run.
    localparam int CYCLE_LIMIT  = 3_000_000;
    // Long receiver hold-off, far beyond what the engine can buffer.
    localparam int LONG_HOLD    = 400;
    // Settle time after the last reply: covers a walk of the whole node pool.
    localparam int DRAIN_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [BC_W-1:0]       cfg_wr_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  func;
    logic [KEY_W-1:0]      key;
    logic [VALUE_W-1:0]    value;
    logic                  out_valid;
    logic                  out_stall;
    logic [STATUS_W-1:0]   status;
    logic [VALUE_W-1:0]    found_value;

    int                    replies_owed;
    int                    mismatches;
    int                    words_taken = 0;
    int                    cycle_count = 0;
    bit                    tx_calm;
    bit                    rx_calm;

    // Keys that have been offered as inserts; lookups and duplicate inserts
    // draw from here so that most traffic hits real chains.
    logic [KEY_W-1:0]      stored_keys[$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    chained_hash_table_engine_top #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .NUM_NODES   (NUM_NODES)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_value (found_value)
    );

    hash_table_checker #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .NUM_NODES   (NUM_NODES)
    ) reply_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .key          (key),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .found_value  (found_value),
        .replies_owed (replies_owed),
        .mismatches   (mismatches)
    );

    // Length of an idle run: mostly none or short, now and then long.
    function automatic int idle_run();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // New key: mostly full-range, some packed near zero or near all ones so
    // that chains collide and the extremes come up often.
    function automatic logic [KEY_W-1:0] fresh_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return KEY_W'($urandom_range(0, 511));
        if (r == 2)
            return 32'hFFFF_FFFF - KEY_W'($urandom_range(0, 511));
        return $urandom;
    endfunction

    function automatic logic [KEY_W-1:0] known_key();
        if (stored_keys.size() == 0)
            return fresh_key();
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    // Offer one word and hold it until the engine takes it. The valid stays
    // high after the handshake; the next task either reuses it or drops it.
    task automatic send_word(input func_t op, input logic [KEY_W-1:0] k,
                             input logic [VALUE_W-1:0] v);
        int gap;
        gap = tx_calm ? 0 : idle_run();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        key      <= k;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == FN_INSERT)
            stored_keys.push_back(k);
    endtask

    // Drop valid and hold off until every reply owed has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_owed != 0)
            @(negedge clk);
    endtask

    // Write the bucket count only with the engine idle.
    task automatic write_bucket_count(input logic [BC_W-1:0] count);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed traffic: inserts of new keys followed later by
    // lookups and duplicate inserts of the same keys; the rest are misses.
    task automatic random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            send_word(FN_INSERT, fresh_key(), $urandom);
        else if (r < 42)
            send_word(FN_INSERT, known_key(), $urandom);
        else if (r < 82)
            send_word(FN_LOOKUP, known_key(), $urandom);
        else
            send_word(FN_LOOKUP, fresh_key(), $urandom);
    endtask

    // Count reply words taken; the receiver uses this to place its long holds.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            words_taken <= words_taken + 1;
    end

    // Receiver: random stall runs, calm stretches, and two long hold-offs
    // that back the engine up until it stalls its input.
    initial
    begin : receiver
        int stall_left;
        int rx_cycle;
        int hold_at;

        out_stall  = 1'b0;
        rx_calm    = 1'b0;
        stall_left = 0;
        rx_cycle   = 0;
        hold_at    = 150;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 256 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (words_taken >= hold_at)
            begin
                out_stall  <= 1'b1;
                stall_left = LONG_HOLD - 1;
                hold_at    = (hold_at < 1000) ? 1000 : 32'h7FFF_FFFF;
            end
            else
            begin
                stall_left = rx_calm ? 0 : idle_run();
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Hard stop in case the engine hangs.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int bc_plan[7];
        int len_plan[7];

        // Bucket counts per phase: mid values, one bucket, above the maximum
        // (clamps to all buckets), zero (taken as one), full count.
        bc_plan  = '{13, 1, 127, 0, 37, 64, 5};
        len_plan = '{300, 80, 400, 60, 400, 300, 260};

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        func        = FN_INSERT;
        key         = '0;
        value       = '0;
        tx_calm     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words at the reset bucket count. Keys 0, 64, 128, 192 and
        // 0x80000000 all land in bucket zero, so chains are walked to the
        // head, the middle, the tail and past the end.
        send_word(FN_LOOKUP, 32'h0000_0000, 32'h0000_0000);   // empty table
        send_word(FN_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_word(FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(FN_INSERT, 32'h0000_0040, 32'h1111_1111);
        send_word(FN_INSERT, 32'h0000_0080, 32'h2222_2222);
        send_word(FN_LOOKUP, 32'h0000_0000, 32'h0000_0000);   // tail of chain
        send_word(FN_LOOKUP, 32'h0000_0040, 32'h0000_0000);   // middle
        send_word(FN_LOOKUP, 32'h0000_0080, 32'h0000_0000);   // head
        send_word(FN_LOOKUP, 32'h0000_00C0, 32'h0000_0000);   // miss after full walk
        send_word(FN_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // value field ignored
        send_word(FN_INSERT, 32'h0000_0000, 32'h1234_5678);   // duplicate key
        send_word(FN_LOOKUP, 32'h0000_0000, 32'hDEAD_BEEF);   // old value kept
        send_word(FN_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);   // top key bit set
        send_word(FN_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        send_word(FN_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
        send_word(FN_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(FN_LOOKUP, 32'h0000_0001, 32'h0000_0000);
        send_word(FN_INSERT, 32'h0000_0001, 32'h0000_0001);
        send_word(FN_LOOKUP, 32'h0000_0001, 32'h0000_0000);

        // Random phases; each bucket count change leaves old chains in place.
        // The pool runs out part way through, after which new keys report
        // full and known keys still report duplicate.
        for (int p = 0; p < 7; p++)
        begin
            write_bucket_count(BC_W'(bc_plan[p]));
            for (int i = 0; i < len_plan[p]; i++)
            begin
                if (i % 50 == 0)
                    tx_calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
                random_word();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && replies_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
